>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset qualifier
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion without reset qualifier
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hslr_pkg.sv
// package: constants and types of the half-size lattice reduce unit
package hslr_pkg;
    localparam int DIG_W = 64;
    localparam int NDIG = 4;
    localparam int TDIG = 2;
    localparam int PLEN_W = 7;
    localparam int LEN_W = 9;
    localparam int S_W = 10;
    localparam int ITER_W = 11;

    typedef logic [DIG_W-1:0] t_word;
    typedef logic [PLEN_W-1:0] t_plen;
    typedef logic [LEN_W-1:0] t_len;

    localparam t_word EL_W0 = 64'h5812631a5cf5d3ed;
    localparam t_word EL_W1 = 64'h14def9dea2f79cd6;
    localparam t_word EL_W2 = 64'h0;
    localparam t_word EL_W3 = 64'h1000000000000000;
    localparam t_len EL_LEN = 9'd253;
    localparam t_len WIDE_LIMIT = 9'd192;
    localparam t_len TARGET_LEN = 9'd127;
    localparam logic [ITER_W-1:0] ITER_LIMIT = 11'd1024;

    // control of one digit step
    typedef struct packed {
        logic sub;
        logic zero;
        logic [5:0] bits;
    } t_alu_ctl;

    // position of highest set bit plus one
    function automatic t_plen plen(input t_word w);
        t_plen l;
        l = '0;
        for (int i = 0; i < DIG_W; i++) begin
            if (w[i]) begin
                l = PLEN_W'(i + 1);
            end
        end
        return l;
    endfunction
endpackage

>>> design/hslr_digit_alu.sv
// one digit of shifted add or subtract
module hslr_digit_alu (
    input  hslr_pkg::t_word    i_a,
    input  hslr_pkg::t_word    i_hi,
    input  hslr_pkg::t_word    i_lo,
    input  hslr_pkg::t_alu_ctl i_ctl,
    input  logic               i_cin,
    output hslr_pkg::t_word    o_z,
    output logic               o_cout
);
    import hslr_pkg::*;

    logic [2*DIG_W-1:0] w_fun;
    t_word w_b;
    logic [DIG_W:0] w_sum;

    // funnel shift of two neighbouring source digits
    assign w_fun = {i_hi, i_lo} << i_ctl.bits;
    assign w_b = i_ctl.zero ? '0 : w_fun[2*DIG_W-1:DIG_W];

    // add or subtract with carry or borrow
    always_comb begin
        if (i_ctl.sub) begin
            w_sum = {1'b0, i_a} - {1'b0, w_b} - {{DIG_W{1'b0}}, i_cin};
        end else begin
            w_sum = {1'b0, i_a} + {1'b0, w_b} + {{DIG_W{1'b0}}, i_cin};
        end
    end

    assign o_z = w_sum[DIG_W-1:0];
    assign o_cout = w_sum[DIG_W];
endmodule

>>> design/half_size_scalar_lattice_reduce_unit.sv
// top level: digit-serial half-size lattice reduction of a scalar
// wide phase over four 64-bit digits of r, narrow phase over three; each iteration steps
//   one digit of r per cycle, and of t in the first two steps, on separate r and t add/sub units
// one scalar at a time, at most 1024 iterations
// a new beat is taken only once the previous result beat has left
// reset: synchronous active-low, clears the sequencer and output valid
module half_size_scalar_lattice_reduce_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // v_limb0, v_limb1, v_limb2, v_limb3
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // c0_low, c0_high, c1_low, c1_high
    output logic [255:0] m_axis_tdata
);
    import hslr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LEN, ST_LENF, ST_CHECK, ST_RUN, ST_DECIDE, ST_OUT
    } t_state;

    t_state r_state;
    t_word r_r2 [NDIG];
    t_word r_r1 [NDIG];
    t_word r_rn [NDIG];
    t_word r_t2 [TDIG];
    t_word r_t1 [TDIG];
    t_word r_tn [TDIG];
    t_plen r_lp [NDIG];
    t_plen r_ln [NDIG];
    t_len r_len1, r_len2;
    logic signed [S_W-1:0] r_s;
    logic r_same, r_wide, r_cr, r_ct;
    logic [ITER_W-1:0] r_iter;
    logic [1:0] r_d;
    logic [255:0] r_out;
    logic r_oval;

    t_alu_ctl w_rctl, w_tctl;
    t_word w_ra, w_rhi, w_rlo, w_rz, w_thi, w_tlo, w_tz;
    t_plen w_rlp, w_rln;
    logic w_rco, w_tco, w_nwide, w_stop, w_same;
    logic [2:0] w_k, w_di;
    t_len w_lenr, w_len0;
    logic signed [S_W-1:0] w_s;
    logic [1:0] w_last;

    // bit length from per-digit hints
    function automatic t_len blen(input t_plen lp [NDIG], input t_plen ln [NDIG],
                                  input logic neg, input logic narrow);
        t_len l;
        t_plen w;
        l = '0;
        for (int i = 0; i < NDIG; i++) begin
            w = neg ? ln[i] : lp[i];
            if (!(narrow && i == NDIG - 1) && w != '0) begin
                l = LEN_W'(DIG_W * i) + LEN_W'(w);
            end
        end
        return l;
    endfunction

    // shift operand digit selection
    assign w_k = {1'b0, r_s[7:6]};
    assign w_di = {1'b0, r_d};
    always_comb begin
        w_rhi = '0;
        w_rlo = '0;
        w_thi = '0;
        w_tlo = '0;
        if (w_di >= w_k) begin
            w_rhi = r_r1[2'(w_di - w_k)];
            if (w_k <= 3'd1) begin
                w_thi = r_t1[1'(w_di - w_k)];
            end
        end
        if (w_di >= w_k + 3'd1) begin
            w_rlo = r_r1[2'(w_di - w_k - 3'd1)];
            if (w_k == 3'd0) begin
                w_tlo = r_t1[1'(w_di - w_k - 3'd1)];
            end
        end
    end

    // digit step control
    always_comb begin
        if (r_state == ST_RUN) begin
            w_ra = r_r2[r_d];
            w_rctl.sub = r_same;
            w_rctl.zero = (r_s < 0) || (r_s >= (r_wide ? S_W'(256) : S_W'(192)));
            w_rctl.bits = r_s[5:0];
        end else begin
            w_ra = r_r1[r_d];
            w_rctl.sub = 1'b0;
            w_rctl.zero = 1'b1;
            w_rctl.bits = '0;
        end
        w_tctl.sub = r_same;
        w_tctl.zero = (r_s < 0) || (r_s >= S_W'(128));
        w_tctl.bits = r_s[5:0];
    end

    hslr_digit_alu u_ralu (
        .i_a(w_ra), .i_hi(w_rhi), .i_lo(w_rlo), .i_ctl(w_rctl),
        .i_cin(r_state == ST_RUN ? r_cr : 1'b0),
        .o_z(w_rz), .o_cout(w_rco)
    );

    hslr_digit_alu u_talu (
        .i_a(r_t2[r_d[0]]), .i_hi(w_thi), .i_lo(w_tlo), .i_ctl(w_tctl),
        .i_cin(r_ct),
        .o_z(w_tz), .o_cout(w_tco)
    );

    // bit-length hints of the current r digit
    assign w_rlp = plen(w_rz);
    assign w_rln = plen(~w_rz);

    // loop control
    assign w_nwide = r_wide && !(r_len2 < WIDE_LIMIT);
    assign w_stop = (!w_nwide && r_len1 <= TARGET_LEN) || (r_iter >= ITER_LIMIT);
    assign w_s = S_W'({1'b0, r_len2}) - S_W'({1'b0, r_len1});
    assign w_same = w_nwide ? (r_r2[3][DIG_W-1] == r_r1[3][DIG_W-1])
                            : (r_r2[2][DIG_W-1] == r_r1[2][DIG_W-1]);
    assign w_last = r_wide ? 2'd3 : 2'd2;
    assign w_lenr = blen(r_lp, r_ln, r_wide ? r_rn[3][DIG_W-1] : r_rn[2][DIG_W-1],
                         !r_wide);
    assign w_len0 = blen(r_lp, r_ln, r_r1[3][DIG_W-1], 1'b0);

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < NDIG; i++) begin
                            r_r1[i] <= s_axis_tdata[DIG_W*i +: DIG_W];
                        end
                        r_r2[0] <= EL_W0;
                        r_r2[1] <= EL_W1;
                        r_r2[2] <= EL_W2;
                        r_r2[3] <= EL_W3;
                        r_t2[0] <= '0;
                        r_t2[1] <= '0;
                        r_t1[0] <= t_word'(1);
                        r_t1[1] <= '0;
                        r_len2 <= EL_LEN;
                        r_wide <= 1'b1;
                        r_iter <= '0;
                        r_d <= '0;
                        r_s <= '0;
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    r_lp[r_d] <= w_rlp;
                    r_ln[r_d] <= w_rln;
                    r_d <= r_d + 2'd1;
                    if (r_d == 2'd3) begin
                        r_state <= ST_LENF;
                    end
                end
                ST_LENF: begin
                    r_len1 <= w_len0;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_wide <= w_nwide;
                    if (r_wide && !w_nwide) begin
                        r_r1[3] <= '0;
                        r_r2[3] <= '0;
                    end
                    if (w_stop) begin
                        r_out <= {r_t1[1], r_t1[0], r_r1[1], r_r1[0]};
                        r_oval <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_s <= w_s;
                        r_same <= w_same;
                        r_rn[3] <= '0;
                        r_lp[3] <= '0;
                        r_ln[3] <= '0;
                        r_d <= '0;
                        r_cr <= 1'b0;
                        r_ct <= 1'b0;
                        r_iter <= r_iter + ITER_W'(1);
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rn[r_d] <= w_rz;
                    r_lp[r_d] <= w_rlp;
                    r_ln[r_d] <= w_rln;
                    r_cr <= w_rco;
                    if (r_d < 2'd2) begin
                        r_tn[r_d[0]] <= w_tz;
                        r_ct <= w_tco;
                    end
                    r_d <= r_d + 2'd1;
                    if (r_d == w_last) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_lenr > r_len1) begin
                        r_r2 <= r_rn;
                        r_t2 <= r_tn;
                        r_len2 <= w_lenr;
                    end else begin
                        r_r2 <= r_r1;
                        r_r1 <= r_rn;
                        r_t2 <= r_t1;
                        r_t1 <= r_tn;
                        r_len2 <= r_len1;
                        r_len1 <= w_lenr;
                    end
                    r_state <= ST_CHECK;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oval <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = r_out;
endmodule

>>> design/hslr_checker.sv
// port-level checker for the lattice reduce unit, with its bind
`include "assert_macros.svh"

module hslr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);
    logic w_in_beat;
    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    // one scalar in flight: no intake while a result waits
    `ASSERT_CLK(a_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "ready with result")
    // an accepted beat is never answered in the next cycle
    `ASSERT_CLK(a_lat, i_clk, i_rst_n, w_in_beat |=> !m_axis_tvalid, "result too early")
    // a stalled result stays valid
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
                "valid dropped")
    // a stalled result keeps its data
    `ASSERT_CLK(a_data, i_clk, i_rst_n,
                m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "data changed")
endmodule

bind half_size_scalar_lattice_reduce_unit hslr_checker u_hslr_checker (.*);

>>> tb/sv/tb.sv
// testbench of the half-size lattice reduce unit: directed and random scalars against a behavioural predictor
`timescale 1ns / 1ps

module tb;
    import hslr_pkg::*;

    localparam int N_RANDOM = 1080;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // v_limb0, v_limb1, v_limb2, v_limb3
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // c0_low, c0_high, c1_low, c1_high
    logic [255:0] m_axis_tdata;

    logic [255:0] pending_scalars[$];
    logic [255:0] expected_pairs[$];
    int           mismatches;
    int           pairs_seen;
    int           send_gap;
    int           recv_gap;
    int           hold_left;
    bit           hold_done;
    int           quiet_cycles;

    half_size_scalar_lattice_reduce_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // signed bit length on the low n bits
    function automatic int signed_len(input logic [255:0] x, input int n);
        logic [255:0] y;
        int l;
        y = x ^ {256{x[n-1]}};
        l = 0;
        for (int i = 0; i < n; i++) begin
            if (y[i]) begin
                l = i + 1;
            end
        end
        return l;
    endfunction

    // shift-and-add reduction, packed as {c1, c0} of 128 bits each
    function automatic logic [255:0] predict_pair(input logic [255:0] v);
        logic [255:0] r2, r1, r, sh, msk;
        logic [127:0] t2, t1, t, tsh;
        int len2, len1, lenr, n, s, iter;
        bit wide, same;
        r2 = {EL_W3, EL_W2, EL_W1, EL_W0};
        r1 = v;
        t2 = '0;
        t1 = 128'd1;
        len2 = int'(EL_LEN);
        len1 = signed_len(r1, 256);
        n = 256;
        msk = '1;
        wide = 1'b1;
        iter = 0;
        forever begin
            if (wide && len2 < int'(WIDE_LIMIT)) begin
                wide = 1'b0;
                n = 192;
                msk = {64'd0, {192{1'b1}}};
                r1 = r1 & msk;
                r2 = r2 & msk;
            end
            if (!wide && len1 <= int'(TARGET_LEN)) break;
            if (iter >= int'(ITER_LIMIT)) break;
            iter++;
            s = len2 - len1;
            same = (r2[n-1] == r1[n-1]);
            sh = (s < 0 || s >= n) ? '0 : ((r1 << s) & msk);
            r = (same ? r2 - sh : r2 + sh) & msk;
            tsh = (s < 0 || s >= 128) ? '0 : (t1 << s);
            t = same ? t2 - tsh : t2 + tsh;
            lenr = signed_len(r, n);
            if (lenr > len1) begin
                r2 = r;
                t2 = t;
                len2 = lenr;
            end else begin
                r2 = r1;
                r1 = r;
                t2 = t1;
                t1 = t;
                len2 = len1;
                len1 = lenr;
            end
        end
        return {t1, r1[127:0]};
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    // random scalar of mixed shape
    function automatic logic [255:0] random_scalar();
        logic [255:0] v;
        int k;
        v = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
        case ($urandom_range(3))
            0: ;
            1: begin
                // below the group order
                v[255:253] = 3'b000;
                v[252] = 1'b0;
            end
            2: begin
                // short magnitude, either sign
                k = $urandom_range(255, 1);
                v = v >> (256 - k);
                if ($urandom_range(1)) v = ~v;
            end
            default: v[255:192] = {64{v[191]}};
        endcase
        return v;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender: offers pending scalars, predicts on acceptance
    always @(posedge i_clk) begin
        logic         nvalid;
        logic [255:0] ndata;
        nvalid = s_axis_tvalid;
        ndata = s_axis_tdata;
        if (!i_rst_n) begin
            nvalid = 1'b0;
            send_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pairs.push_back(predict_pair(s_axis_tdata));
                nvalid = 1'b0;
            end
            if (!nvalid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_scalars.size() > 0) begin
                    ndata = pending_scalars.pop_front();
                    nvalid = 1'b1;
                    send_gap <= pick_gap();
                end
            end
        end
        s_axis_tvalid <= nvalid;
        s_axis_tdata <= ndata;
    end

    // receiver: checks result beats, random back-pressure and one long hold
    always @(posedge i_clk) begin
        logic [255:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                pairs_seen <= pairs_seen + 1;
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", m_axis_tdata);
                end else begin
                    want = expected_pairs.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (m_axis_tdata[f*64 +: 64] !== want[f*64 +: 64]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("beat %0d field %0d: expected %h got %h",
                                         pairs_seen, f, want[f*64 +: 64],
                                         m_axis_tdata[f*64 +: 64]);
                        end
                    end
                end
            end
            if (!hold_done && pairs_seen == 40) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [255:0] el;
        el = {EL_W3, EL_W2, EL_W1, EL_W0};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        pairs_seen = 0;
        hold_done = 1'b0;
        quiet_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_left = 0;

        // directed: zero never converges, minus one and extremes of the field
        pending_scalars.push_back('0);
        pending_scalars.push_back('1);
        pending_scalars.push_back(256'd1);
        pending_scalars.push_back(el);
        pending_scalars.push_back(el - 1);
        pending_scalars.push_back(el + 1);
        pending_scalars.push_back(-el);
        pending_scalars.push_back(256'd1 << 255);
        pending_scalars.push_back(~(256'd1 << 255));
        pending_scalars.push_back(256'd1 << 127);
        pending_scalars.push_back((256'd1 << 127) - 1);
        pending_scalars.push_back(256'd1 << 191);
        pending_scalars.push_back({64{4'ha}});
        pending_scalars.push_back({64{4'h5}});
        pending_scalars.push_back(256'd2);
        pending_scalars.push_back(-256'sd2);
        pending_scalars.push_back(el << 1);
        pending_scalars.push_back({4{64'hffffffff00000000}});
        for (int i = 0; i < N_RANDOM; i++)
            pending_scalars.push_back(random_scalar());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_scalars.size() == 0 && !s_axis_tvalid && expected_pairs.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
